[hdl/websocket_frame_parser_defines.svh]
// ----------------------------------------------------------------------------
// WebSocket frame parser assertion macros
// Property macros used by wsfp_step, the module that carries assertions.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_PARSER_DEFINES_SVH
`define WEBSOCKET_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define WSFP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("websocket_frame_parser: same-cycle property failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define WSFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("websocket_frame_parser: next-cycle property failed");

`endif

[hdl/wsfp_pkg.sv]
// ----------------------------------------------------------------------------
// WebSocket frame parser package
// Types, codes and constants shared by the frame parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wsfp_pkg;

  // Parser phase, one-hot.
  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_ERROR   = 3'b100
  } phase_t;

  // Result kind codes.
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_CTRL   = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Frame type codes reported with msg_end.
  localparam logic [2:0] FT_NONE   = 3'd0;
  localparam logic [2:0] FT_TEXT   = 3'd1;
  localparam logic [2:0] FT_BINARY = 3'd2;
  localparam logic [2:0] FT_CLOSE  = 3'd3;
  localparam logic [2:0] FT_PING   = 3'd4;
  localparam logic [2:0] FT_PONG   = 3'd5;

  // Opcodes.
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // Header field masks and limits.
  localparam logic [7:0] RSV_MASK     = 8'h70;
  localparam logic [7:0] FIN_MASK     = 8'h80;
  localparam logic [7:0] LEN7_MASK    = 8'h7F;
  localparam logic [7:0] OP_MASK      = 8'h0F;
  localparam logic [6:0] CTRL_MAX_LEN = 7'd125;
  localparam logic [6:0] LEN_EXT16    = 7'd126;
  localparam logic [6:0] LEN_EXT64    = 7'd127;

  localparam logic [31:0] MAX_MSG_LEN_RESET = 32'd65536;

  // One result item.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       frame_end;
    logic       msg_end;
    logic [2:0] frame_type;
  } result_t;

endpackage

[hdl/wsfp_in_reg.sv]
// ----------------------------------------------------------------------------
// WebSocket frame parser input register
// Captures one received byte and holds it until the step logic takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsfp_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       advance,
  output logic       hold_valid,
  output logic [7:0] hold_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       load;

  // The held byte leaves whenever the next stage advances.
  assign in_stall = valid_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_byte;
    end
  end

  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

endmodule

[hdl/wsfp_step.sv]
// ----------------------------------------------------------------------------
// WebSocket frame parser step logic
// Parser state and the per-byte decision: header checks, length and mask key
// collection, payload unmasking and frame and message end reporting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "websocket_frame_parser_defines.svh"

module wsfp_step
  import wsfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] max_message_len,
  input  logic        step_en,
  input  logic [7:0]  step_byte,
  output result_t     res
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hcnt_r, hcnt_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [6:0]  short_r, short_nxt;
  logic [63:0] flen_r, flen_nxt;     // length while collecting, bytes left in payload
  logic [31:0] key_r, key_nxt;
  logic [1:0]  bidx_r, bidx_nxt;     // payload index modulo four
  logic [1:0]  open_r, open_nxt;
  logic [31:0] msg_r, msg_nxt;

  logic [7:0]  op_bits;
  logic [3:0]  op;
  logic        ctrl;
  logic        fin;
  logic [3:0]  ext_n;
  logic [3:0]  hcnt_inc;
  logic [63:0] len;
  logic        bad;
  logic        too_long;
  logic [7:0]  key_byte;
  logic [1:0]  open_tmp;
  logic        end_frame;

  assign op_bits = first_r & OP_MASK;
  assign op      = op_bits[3:0];
  assign ctrl    = op[3];
  assign fin     = (first_r & FIN_MASK) != 8'h00;

  assign ext_n    = (short_r == LEN_EXT16) ? 4'd2 : ((short_r == LEN_EXT64) ? 4'd8 : 4'd0);
  assign hcnt_inc = hcnt_r + 4'd1;
  assign len      = (ext_n == 4'd0) ? {57'd0, short_r} : flen_r;

  always_comb begin
    bad = 1'b0;
    if ((first_r & RSV_MASK) != 8'h00) bad = 1'b1;
    if ((step_byte & FIN_MASK) == 8'h00) bad = 1'b1;
    if (!(op == OP_CONT || op == OP_TEXT || op == OP_BINARY ||
          op == OP_CLOSE || op == OP_PING || op == OP_PONG)) bad = 1'b1;
    if (ctrl && !fin) bad = 1'b1;
    if (ctrl && (step_byte[6:0] > CTRL_MAX_LEN)) bad = 1'b1;
    if (op == OP_CONT && open_r == 2'd0) bad = 1'b1;
    if ((op == OP_TEXT || op == OP_BINARY) && open_r != 2'd0) bad = 1'b1;
  end

  // A data frame may not push the message past the configured maximum.
  assign too_long = (msg_r > max_message_len) ||
                    (len > {32'd0, max_message_len - msg_r});

  always_comb begin
    case (bidx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  assign open_tmp = (op != OP_CONT) ? op[1:0] : open_r;

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    first_nxt = first_r;
    short_nxt = short_r;
    flen_nxt  = flen_r;
    key_nxt   = key_r;
    bidx_nxt  = bidx_r;
    open_nxt  = open_r;
    msg_nxt   = msg_r;
    end_frame = 1'b0;
    res       = '0;
    res.kind  = KIND_HEADER;

    unique case (phase_r)
      PH_HEADER: begin
        if (hcnt_r == 4'd0) begin
          first_nxt = step_byte;
          hcnt_nxt  = 4'd1;
        end else if (hcnt_r == 4'd1) begin
          if (bad) begin
            phase_nxt = PH_ERROR;
            res.kind  = KIND_ERROR;
          end else begin
            short_nxt = step_byte[6:0];
            flen_nxt  = '0;
            key_nxt   = '0;
            hcnt_nxt  = 4'd2;
          end
        end else begin
          if (hcnt_r < 4'd2 + ext_n) begin
            flen_nxt = {flen_r[55:0], step_byte};
          end else begin
            key_nxt = {key_r[23:0], step_byte};
          end
          hcnt_nxt = hcnt_inc;
          // The mask key is always last, so the length is complete here.
          if (hcnt_inc == 4'd6 + ext_n) begin
            if (!ctrl && too_long) begin
              phase_nxt = PH_ERROR;
              res.kind  = KIND_ERROR;
            end else begin
              phase_nxt = PH_PAYLOAD;
              flen_nxt  = len;
              bidx_nxt  = 2'd0;
              end_frame = (len == 64'd0);
            end
          end
        end
      end
      PH_PAYLOAD: begin
        res.data = step_byte ^ key_byte;
        if (ctrl) begin
          res.kind = KIND_CTRL;
        end else begin
          res.kind = KIND_DATA;
          msg_nxt  = msg_r + 32'd1;
        end
        bidx_nxt  = bidx_r + 2'd1;
        flen_nxt  = flen_r - 64'd1;
        end_frame = (flen_r == 64'd1);
      end
      PH_ERROR: begin
        res.kind = KIND_ERROR;
      end
      default: begin
        phase_nxt = PH_ERROR;
        res.kind  = KIND_ERROR;
      end
    endcase

    if (end_frame) begin
      res.frame_end = 1'b1;
      phase_nxt     = PH_HEADER;
      hcnt_nxt      = 4'd0;
      if (ctrl) begin
        res.msg_end    = 1'b1;
        res.frame_type = (op == OP_CLOSE) ? FT_CLOSE :
                         ((op == OP_PING) ? FT_PING : FT_PONG);
      end else if (fin) begin
        res.msg_end    = 1'b1;
        res.frame_type = (open_tmp == OP_TEXT[1:0]) ? FT_TEXT : FT_BINARY;
        open_nxt       = 2'd0;
        msg_nxt        = 32'd0;
      end else begin
        open_nxt = open_tmp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hcnt_r  <= 4'd0;
      first_r <= 8'd0;
      short_r <= 7'd0;
      flen_r  <= 64'd0;
      key_r   <= 32'd0;
      bidx_r  <= 2'd0;
      open_r  <= 2'd0;
      msg_r   <= 32'd0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      first_r <= first_nxt;
      short_r <= short_nxt;
      flen_r  <= flen_nxt;
      key_r   <= key_nxt;
      bidx_r  <= bidx_nxt;
      open_r  <= open_nxt;
      msg_r   <= msg_nxt;
    end
  end

  `WSFP_ASSERT_NOW(a_done_ends_frame, step_en && res.msg_end, res.frame_end)
  `WSFP_ASSERT_NEXT(a_error_sticky, phase_r == PH_ERROR, phase_r == PH_ERROR)
  `WSFP_ASSERT_NOW(a_payload_nonempty, phase_r == PH_PAYLOAD, flen_r != 64'd0)
  `WSFP_ASSERT_NOW(a_open_op_legal, 1'b1, open_r != 2'd3)

endmodule

[hdl/wsfp_out_reg.sv]
// ----------------------------------------------------------------------------
// WebSocket frame parser result register
// Holds one result until the receiver takes it and tells the front when the
// parser may advance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wsfp_out_reg
  import wsfp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // Room exists when the register is empty or is being emptied this cycle.
  assign advance = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

[hdl/websocket_frame_parser.sv]
// Accepted bytes wait in the input register; results are registered for out_*.
// Throughput: one byte per clock while out_stall is low; the parser step is combinational.
// A stalled result holds the parser; the input register then takes one more byte.
// Reset (rst_n low, synchronous) clears all parser state and empties both registers.
// After reset the message limit is 65536 bytes and the parser waits for a header.
// ----------------------------------------------------------------------------
// WebSocket frame parser
// Server-side frame deframer that takes one received byte per request and
// gives one result per byte: header, unmasked data or control payload
// or protocol error, with frame and message end marks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module websocket_frame_parser
  import wsfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Message length limit register.
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  // Received byte requests.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  // Result requests.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic        out_frame_end,
  output logic        out_msg_end,
  output logic [2:0]  out_frame_type
);

  logic [31:0] max_len_r, max_len_nxt;
  logic        advance;
  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        step_en;
  result_t     step_res;
  result_t     out_res;

  // The user must write the limit register only while no request is in flight; the block does not enforce it.
  assign max_len_nxt = cfg_wr_en ? cfg_wr_data : max_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_MSG_LEN_RESET;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  // Stage one: the accepted byte waits here for the parser step.
  wsfp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  // The parser state moves only when a held byte goes into the result register.
  assign step_en = hold_valid && advance;

  wsfp_step u_step (
    .clk             (clk),
    .rst_n           (rst_n),
    .max_message_len (max_len_r),
    .step_en         (step_en),
    .step_byte       (hold_byte),
    .res             (step_res)
  );

  // Stage two: the result waits here for the receiver.
  wsfp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en),
    .res       (step_res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind       = out_res.kind;
  assign out_byte       = out_res.data;
  assign out_frame_end  = out_res.frame_end;
  assign out_msg_end    = out_res.msg_end;
  assign out_frame_type = out_res.frame_type;

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// WebSocket frame parser testbench
// Streams masked frames into the parser one byte per request and checks each
// result against a cycle-free shadow of the deframer. A short scripted part
// covers every opcode and the short and 16-bit length encodings. Random
// well-formed traffic runs under several message limits with random gaps
// and stalls on both sides. One randomly chosen protocol violation closes
// the run, since errors stick until reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import wsfp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int IDLE_PCT     = 13;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 2;
  localparam int MAX_REPORTS  = 10;
  localparam int DIR_ROWS     = 43;

  // Ways to encode a payload length in the header.
  localparam int FORM_SHORT = 0;
  localparam int FORM_EXT16 = 1;
  localparam int FORM_EXT64 = 2;

  // Low two opcode bits of an open fragmented message; zero means none.
  localparam logic [1:0] MSG_NONE = 2'd0;

  // Protocol violations that can close the run.
  typedef enum int {
    BAD_RESERVED, BAD_UNMASKED, BAD_OPCODE, BAD_CTRL_FRAGMENT,
    BAD_CTRL_LENGTH, BAD_ORPHAN_CONT, BAD_DATA_MIDMSG, BAD_TOO_LONG
  } fault_case_t;

  localparam result_t R_HDR = '{KIND_HEADER, 8'h00, 1'b0, 1'b0, FT_NONE};

  // One scripted request; res is only used when typed is set.
  typedef struct {
    logic [7:0] b;
    bit         typed;
    result_t    res;
  } script_row_t;

  // The scripted part walks through these frames in order:
  //   binary start without FIN, all-ones mask, payload FF 00
  //   ping of one byte inside the open message, zero mask
  //   continuation with FIN and one payload byte, closing the binary message
  //   text with FIN using the 16-bit length form
  //   empty close, then empty pong
  script_row_t dir_script [DIR_ROWS] = '{
    '{8'h02, 1'b1, R_HDR}, '{8'h82, 1'b1, R_HDR},
    '{8'hFF, 1'b1, R_HDR}, '{8'hFF, 1'b1, R_HDR},
    '{8'hFF, 1'b1, R_HDR}, '{8'hFF, 1'b1, R_HDR},
    '{8'hFF, 1'b1, '{KIND_DATA, 8'h00, 1'b0, 1'b0, FT_NONE}},
    '{8'h00, 1'b1, '{KIND_DATA, 8'hFF, 1'b1, 1'b0, FT_NONE}},
    '{8'h89, 1'b1, R_HDR}, '{8'h81, 1'b1, R_HDR},
    '{8'h00, 1'b1, R_HDR}, '{8'h00, 1'b1, R_HDR},
    '{8'h00, 1'b1, R_HDR}, '{8'h00, 1'b1, R_HDR},
    '{8'h5A, 1'b1, '{KIND_CTRL, 8'h5A, 1'b1, 1'b1, FT_PING}},
    '{8'h80, 1'b1, R_HDR}, '{8'h81, 1'b1, R_HDR},
    '{8'h12, 1'b1, R_HDR}, '{8'h34, 1'b1, R_HDR},
    '{8'h56, 1'b1, R_HDR}, '{8'h78, 1'b1, R_HDR},
    '{8'hA5, 1'b0, R_HDR},
    '{8'h81, 1'b1, R_HDR}, '{8'hFE, 1'b1, R_HDR},
    '{8'h00, 1'b1, R_HDR}, '{8'h01, 1'b1, R_HDR},
    '{8'h01, 1'b1, R_HDR}, '{8'h02, 1'b1, R_HDR},
    '{8'h03, 1'b1, R_HDR}, '{8'h04, 1'b1, R_HDR},
    '{8'h61, 1'b0, R_HDR},
    '{8'h88, 1'b1, R_HDR}, '{8'h80, 1'b1, R_HDR},
    '{8'h00, 1'b1, R_HDR}, '{8'h00, 1'b1, R_HDR},
    '{8'h00, 1'b1, R_HDR},
    '{8'h00, 1'b1, '{KIND_HEADER, 8'h00, 1'b1, 1'b1, FT_CLOSE}},
    '{8'h8A, 1'b1, R_HDR}, '{8'h80, 1'b1, R_HDR},
    '{8'hC3, 1'b1, R_HDR}, '{8'h3C, 1'b1, R_HDR},
    '{8'hA5, 1'b1, R_HDR},
    '{8'h5A, 1'b1, '{KIND_HEADER, 8'h00, 1'b1, 1'b1, FT_PONG}}
  };

  // DUT signals. Every input starts at a known value.
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [31:0] cfg_wr_data = 32'h0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte     = 8'h00;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic        out_frame_end;
  logic        out_msg_end;
  logic [2:0]  out_frame_type;

  // Shadow of the deframer state, advanced once per accepted request.
  phase_t      sh_phase;
  int          sh_hdr_cnt;
  logic [7:0]  sh_hdr0;
  logic [6:0]  sh_len7;
  logic [63:0] sh_flen;
  logic [31:0] sh_key;
  logic [63:0] sh_pos;
  logic [1:0]  sh_open_op;
  logic [31:0] sh_msg_total;
  logic [31:0] sh_limit;

  // Results still owed by the parser, oldest first.
  result_t pending_results [$];

  int  fault_count      = 0;
  int  cycle_count      = 0;
  int  bytes_sent       = 0;
  int  frames_sent      = 0;
  int  messages_closed  = 0;
  int  controls_closed  = 0;
  bit  calm             = 1'b0;
  bit  squeeze_req      = 1'b0;
  fault_case_t tail_case;

  websocket_frame_parser dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_frame_end  (out_frame_end),
    .out_msg_end    (out_msg_end),
    .out_frame_type (out_frame_type)
  );

  always #10 clk = ~clk;

  // Closes the current frame: marks the end, reports a finished message or
  // control frame with its type, and returns the shadow to the header phase.
  // A text or binary opener records the message type even without FIN, so a
  // later continuation with FIN can report it.
  function automatic void close_frame(inout result_t r);
    logic [3:0] op;
    op = sh_hdr0[3:0];
    r.frame_end = 1'b1;
    if (op[3]) begin
      r.msg_end = 1'b1;
      r.frame_type = (op == OP_CLOSE) ? FT_CLOSE : (op == OP_PING) ? FT_PING : FT_PONG;
    end else begin
      if (op != OP_CONT) begin
        sh_open_op = op[1:0];
      end
      if (sh_hdr0[7]) begin
        r.msg_end = 1'b1;
        r.frame_type = (sh_open_op == OP_TEXT[1:0]) ? FT_TEXT : FT_BINARY;
        sh_open_op = MSG_NONE;
        sh_msg_total = 32'd0;
      end
    end
    sh_phase = PH_HEADER;
    sh_hdr_cnt = 0;
    sh_pos = 64'd0;
  endfunction

  // Works out the result that one received byte must produce.
  function automatic result_t deframe_predict(input logic [7:0] b);
    result_t    r;
    logic [3:0] op;
    logic [7:0] k;
    logic       bad;
    int         ext_n;
    r = '0;
    op = sh_hdr0[3:0];
    if (sh_phase == PH_ERROR) begin
      r.kind = KIND_ERROR;
    end else if (sh_phase == PH_PAYLOAD) begin
      // Mask key bytes rotate most significant first.
      k = sh_key[8 * (3 - sh_pos[1:0]) +: 8];
      r.data = b ^ k;
      if (op[3]) begin
        r.kind = KIND_CTRL;
      end else begin
        r.kind = KIND_DATA;
        sh_msg_total = sh_msg_total + 32'd1;
      end
      sh_pos = sh_pos + 64'd1;
      if (sh_pos == sh_flen) begin
        close_frame(r);
      end
    end else if (sh_hdr_cnt == 0) begin
      sh_hdr0 = b;
      sh_hdr_cnt = 1;
    end else if (sh_hdr_cnt == 1) begin
      bad = ((sh_hdr0 & RSV_MASK) != 8'h00) || !b[7]
          || !(op inside {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG})
          || (op[3] && (sh_hdr0 & FIN_MASK) == 8'h00)
          || (op[3] && b[6:0] > CTRL_MAX_LEN)
          || (op == OP_CONT && sh_open_op == MSG_NONE)
          || ((op == OP_TEXT || op == OP_BINARY) && sh_open_op != MSG_NONE);
      if (bad) begin
        sh_phase = PH_ERROR;
        r.kind = KIND_ERROR;
      end else begin
        sh_len7 = b[6:0];
        sh_flen = 64'd0;
        sh_key = 32'd0;
        sh_hdr_cnt = 2;
      end
    end else begin
      ext_n = (sh_len7 == LEN_EXT16) ? 2 : (sh_len7 == LEN_EXT64) ? 8 : 0;
      if (sh_hdr_cnt < 2 + ext_n) begin
        sh_flen = {sh_flen[55:0], b};
      end else begin
        sh_key = {sh_key[23:0], b};
      end
      sh_hdr_cnt = sh_hdr_cnt + 1;
      if (sh_hdr_cnt == 6 + ext_n) begin
        if (ext_n == 0) begin
          sh_flen = {57'd0, sh_len7};
        end
        // Data frames must fit in what is left of the message limit.
        if (!op[3] && (sh_msg_total > sh_limit
            || sh_flen > {32'd0, sh_limit - sh_msg_total})) begin
          sh_phase = PH_ERROR;
          r.kind = KIND_ERROR;
        end else begin
          sh_pos = 64'd0;
          sh_phase = PH_PAYLOAD;
          if (sh_flen == 64'd0) begin
            close_frame(r);
          end
        end
      end
    end
    return r;
  endfunction

  task automatic note_fault(input string what);
    fault_count++;
    if (fault_count <= MAX_REPORTS) begin
      $display("[%0t] %s", $time, what);
    end
  endtask

  // Offers one byte and waits for it to be taken. The payload holds still
  // while the parser stalls. Called right after a rising edge; returns at the
  // edge that accepted the request, without touching in_valid there, so a
  // following request can keep valid high.
  task automatic offer_byte(input logic [7:0] b, input bit typed = 1'b0,
                            input result_t want = '0);
    result_t predicted;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    predicted = deframe_predict(b);
    if (predicted.msg_end) begin
      if (predicted.kind == KIND_CTRL || sh_hdr0[3]) begin
        controls_closed++;
      end else begin
        messages_closed++;
      end
    end
    pending_results.push_back(typed ? want : predicted);
    bytes_sent++;
  endtask

  // Sends a complete masked frame with a random key and random payload.
  task automatic send_frame(input bit fin, input logic [3:0] op, input int len,
                            input int form);
    logic [6:0]  l7;
    logic [63:0] len64;
    len64 = 64'(len);
    l7 = (form == FORM_EXT16) ? LEN_EXT16 : (form == FORM_EXT64) ? LEN_EXT64 : len64[6:0];
    offer_byte({fin, 3'b000, op});
    offer_byte({1'b1, l7});
    if (form == FORM_EXT16) begin
      offer_byte(len64[15:8]);
      offer_byte(len64[7:0]);
    end else if (form == FORM_EXT64) begin
      for (int i = 7; i >= 0; i--) begin
        offer_byte(len64[8 * i +: 8]);
      end
    end
    repeat (4) offer_byte(8'($urandom_range(255)));
    repeat (len) offer_byte(8'($urandom_range(255)));
    frames_sent++;
  endtask

  // Picks one legal frame given the open message and the room left under the
  // limit. Lengths are mostly short, with rare long frames and occasional
  // frames that exactly fill the remaining room.
  task automatic random_frame();
    int              pick;
    int              len;
    int              form;
    bit              fin;
    logic [3:0]      op;
    longint unsigned room;
    pick = $urandom_range(99);
    if (pick < 25) begin
      case ($urandom_range(2))
        0:       op = OP_CLOSE;
        1:       op = OP_PING;
        default: op = OP_PONG;
      endcase
      len = ($urandom_range(99) < 10) ? int'(CTRL_MAX_LEN) : $urandom_range(12);
      send_frame(1'b1, op, len, FORM_SHORT);
    end else begin
      if (sh_open_op != MSG_NONE) begin
        op = OP_CONT;
      end else begin
        op = $urandom_range(1) ? OP_TEXT : OP_BINARY;
      end
      fin = ($urandom_range(99) < 45);
      room = (sh_msg_total >= sh_limit) ? 0 : longint'(sh_limit - sh_msg_total);
      pick = $urandom_range(99);
      if (pick < 10) begin
        len = 0;
      end else if (pick < 80) begin
        len = $urandom_range(1, 12);
      end else if (pick < 90) begin
        len = $urandom_range(13, 125);
      end else if (pick < 98) begin
        len = $urandom_range(126, 300);
      end else begin
        len = $urandom_range(301, 600);
      end
      if (room < 600 && $urandom_range(99) < 15) begin
        len = int'(room);
      end
      if (len > room) begin
        len = int'(room);
      end
      if (len > 125) begin
        form = ($urandom_range(99) < 20) ? FORM_EXT64 : FORM_EXT16;
      end else begin
        pick = $urandom_range(99);
        form = (pick < 8) ? FORM_EXT16 : (pick < 12) ? FORM_EXT64 : FORM_SHORT;
      end
      send_frame(fin, op, len, form);
    end
  endtask

  // Random legal traffic for about the given number of bytes. A message left
  // open is closed with an empty continuation so the next limit starts clean.
  task automatic random_traffic(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      random_frame();
    end
    if (sh_open_op != MSG_NONE) begin
      send_frame(1'b1, OP_CONT, 0, FORM_SHORT);
    end
  endtask

  // Rewrites the message limit once every owed result has come back.
  task automatic set_msg_limit(input logic [31:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sh_limit = value;
  endtask

  // Ends the stream with one protocol violation, then a few more bytes that
  // must all come back as errors because the error state is sticky.
  task automatic error_tail();
    logic [3:0] bad_op;
    tail_case = fault_case_t'($urandom_range(7));
    case (tail_case)
      BAD_RESERVED: begin
        offer_byte({1'b1, 3'($urandom_range(1, 7)), OP_BINARY});
        offer_byte(8'h80);
      end
      BAD_UNMASKED: begin
        offer_byte({1'b1, 3'b000, OP_TEXT});
        offer_byte(8'($urandom_range(127)));
      end
      BAD_OPCODE: begin
        do begin
          bad_op = 4'($urandom_range(15));
        end while (bad_op inside {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG});
        offer_byte({1'b1, 3'b000, bad_op});
        offer_byte(8'h80);
      end
      BAD_CTRL_FRAGMENT: begin
        offer_byte({1'b0, 3'b000, OP_PING});
        offer_byte(8'h80);
      end
      BAD_CTRL_LENGTH: begin
        offer_byte({1'b1, 3'b000, OP_CLOSE});
        offer_byte({1'b1, 7'($urandom_range(126, 127))});
      end
      BAD_ORPHAN_CONT: begin
        offer_byte({1'b1, 3'b000, OP_CONT});
        offer_byte(8'h80);
      end
      BAD_DATA_MIDMSG: begin
        send_frame(1'b0, OP_TEXT, 3, FORM_SHORT);
        offer_byte({1'b1, 3'b000, OP_BINARY});
        offer_byte(8'h80);
      end
      default: begin
        // A 64-bit length of 2^32 is beyond any 32-bit limit.
        offer_byte({1'b1, 3'b000, OP_BINARY});
        offer_byte({1'b1, LEN_EXT64});
        for (int i = 7; i >= 0; i--) begin
          offer_byte((i == 4) ? 8'h01 : 8'h00);
        end
        repeat (4) offer_byte(8'($urandom_range(255)));
      end
    endcase
    repeat (8) offer_byte(8'($urandom_range(255)));
  endtask

  // Result side: random stalls, one long hold when the sender asks for it,
  // and no stalls at all while the calm stretch runs. The hold is counted
  // here so the sender keeps offering bytes and the parser fills up.
  initial begin : result_sink
    int  hold_left;
    bit  hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze_req && !hold_used) begin
        hold_left = HOLD_CYCLES;
        hold_used = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
      @(posedge clk);
    end
  end

  // Every accepted result is matched against the oldest owed result.
  always @(posedge clk) begin
    result_t oldest;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_fault($sformatf("result with nothing owed: kind=%0d byte=%02h",
                             out_kind, out_byte));
      end else begin
        oldest = pending_results.pop_front();
        if (out_kind != oldest.kind || out_byte != oldest.data
            || out_frame_end != oldest.frame_end
            || out_msg_end != oldest.msg_end
            || out_frame_type != oldest.frame_type) begin
          note_fault($sformatf({"mismatch: expected kind=%0d byte=%02h end=%b done=%b ",
                                "type=%0d, got kind=%0d byte=%02h end=%b done=%b type=%0d"},
                               oldest.kind, oldest.data, oldest.frame_end,
                               oldest.msg_end, oldest.frame_type,
                               out_kind, out_byte, out_frame_end,
                               out_msg_end, out_frame_type));
        end
      end
    end
  end

  // Hard stop in case the parser wedges.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still owed",
             cycle_count, pending_results.size());
    $display("tb: errors");
    $finish;
  end

  initial begin : stimulus
    int waited;
    sh_phase     = PH_HEADER;
    sh_hdr_cnt   = 0;
    sh_hdr0      = 8'h00;
    sh_len7      = 7'd0;
    sh_flen      = 64'd0;
    sh_key       = 32'd0;
    sh_pos       = 64'd0;
    sh_open_op   = MSG_NONE;
    sh_msg_total = 32'd0;
    sh_limit     = MAX_MSG_LEN_RESET;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Scripted frames under the reset limit.
    for (int i = 0; i < DIR_ROWS; i++) begin
      offer_byte(dir_script[i].b, dir_script[i].typed, dir_script[i].res);
    end

    // A zero limit only lets empty data frames through; control frames are
    // not bound by it.
    set_msg_limit(32'd0);
    random_traffic(100);

    // Largest limit, with the long result hold to back the parser up.
    set_msg_limit(32'hFFFF_FFFF);
    squeeze_req = 1'b1;
    random_traffic(220);

    // Tight limit that frames often fill exactly, run without any gaps.
    set_msg_limit(32'd37);
    calm = 1'b1;
    random_traffic(130);
    calm = 1'b0;

    set_msg_limit(32'($urandom_range(1, 5000)));
    random_traffic(130);

    set_msg_limit(32'hFFFF_FFFF);
    random_traffic(110);

    error_tail();
    in_valid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      note_fault($sformatf("%0d results never arrived", pending_results.size()));
      fault_count += pending_results.size() - 1;
    end

    $display("summary: %0d bytes in %0d frames, %0d data messages and %0d control frames",
             bytes_sent, frames_sent, messages_closed, controls_closed);
    $display("summary: limits 0 to 0xFFFFFFFF, closing violation %s, %0d faults",
             tail_case.name(), fault_count);
    if (fault_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/wsfp_pkg.sv
hdl/wsfp_in_reg.sv
hdl/wsfp_step.sv
hdl/wsfp_out_reg.sv
hdl/websocket_frame_parser.sv
tb/sv/tb.sv
